// ===== rtl/tlde_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlde_pkg
// Shared types, widths and constants of the link delay emulator.
// ----------------------------------------------------------------------------
package tlde_pkg;

    localparam int BUF_DEPTH = 32;
    localparam int IDX_W     = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;

    localparam int TIME_W    = 32;
    localparam int VAL_W     = 32;
    localparam int SLOT_W    = 3 * VAL_W;     // x, y, heading of one sample
    localparam int JIT_W     = 10;
    localparam int CMP_W     = 34;            // signed compare width, no wrap
    localparam int SPER_W    = 16;
    localparam int RPER_W    = 20;
    localparam int DLY_W     = 16;

    // stream payload layout
    localparam int S_DATA_W  = 144;           // 138 used bits, padded to bytes
    localparam int M_DATA_W  = 96;

    // APB
    localparam int ADDR_W    = 5;
    localparam int DATA_W    = 32;

    localparam logic [SPER_W-1:0] SAMPLE_PERIOD_RST  = 16'd33;
    localparam logic [RPER_W-1:0] RESTART_PERIOD_RST = 20'd10000;
    localparam logic [DLY_W-1:0]  NORMAL_DELAY_RST   = 16'd0;
    localparam logic [DLY_W-1:0]  ABNORMAL_DELAY_RST = 16'd0;
    localparam logic [DLY_W-1:0]  SENSOR_DELAY_RST   = 16'd0;
    localparam logic [DLY_W-1:0]  MIN_GAP_RST        = 16'd1;

    typedef enum logic [2:0] {
        REG_SAMPLE_PERIOD  = 3'd0,
        REG_RESTART_PERIOD = 3'd1,
        REG_NORMAL_DELAY   = 3'd2,
        REG_ABNORMAL_DELAY = 3'd3,
        REG_SENSOR_DELAY   = 3'd4,
        REG_MIN_GAP        = 3'd5
    } reg_idx_t;

    typedef struct packed {
        logic [SPER_W-1:0] sample_period;
        logic [RPER_W-1:0] restart_period;
        logic [DLY_W-1:0]  normal_delay;
        logic [DLY_W-1:0]  abnormal_delay;
        logic [DLY_W-1:0]  sensor_delay;
        logic [DLY_W-1:0]  min_release_gap;
    } tlde_cfg_t;

    typedef logic [IDX_W-1:0] idx_t;

    function automatic idx_t next_slot(input idx_t idx);
        idx_t res;
        if (idx == idx_t'(BUF_DEPTH - 1))
        begin
            res = '0;
        end
        else
        begin
            res = idx + idx_t'(1);
        end
        return res;
    endfunction

endpackage

// ===== rtl/tlde_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlde_regs
// APB register file holding the delay, period and release-gap settings.
// ----------------------------------------------------------------------------
module tlde_regs (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [tlde_pkg::ADDR_W-1:0] paddr,
    input  logic [tlde_pkg::DATA_W-1:0] pwdata,
    output logic [tlde_pkg::DATA_W-1:0] prdata,
    output logic                       pready,
    output tlde_pkg::tlde_cfg_t        cfg
);
    import tlde_pkg::*;

    tlde_cfg_t cfg_reg;
    reg_idx_t  sel_idx;
    logic      wr_en;

    assign pready  = 1'b1;
    assign sel_idx = reg_idx_t'(paddr[ADDR_W-1:2]);
    assign wr_en   = psel && penable && pwrite && pready;
    assign cfg     = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sample_period   <= SAMPLE_PERIOD_RST;
            cfg_reg.restart_period  <= RESTART_PERIOD_RST;
            cfg_reg.normal_delay    <= NORMAL_DELAY_RST;
            cfg_reg.abnormal_delay  <= ABNORMAL_DELAY_RST;
            cfg_reg.sensor_delay    <= SENSOR_DELAY_RST;
            cfg_reg.min_release_gap <= MIN_GAP_RST;
        end
        else if (wr_en)
        begin
            case (sel_idx)
                REG_SAMPLE_PERIOD:  cfg_reg.sample_period   <= pwdata[SPER_W-1:0];
                REG_RESTART_PERIOD: cfg_reg.restart_period  <= pwdata[RPER_W-1:0];
                REG_NORMAL_DELAY:   cfg_reg.normal_delay    <= pwdata[DLY_W-1:0];
                REG_ABNORMAL_DELAY: cfg_reg.abnormal_delay  <= pwdata[DLY_W-1:0];
                REG_SENSOR_DELAY:   cfg_reg.sensor_delay    <= pwdata[DLY_W-1:0];
                REG_MIN_GAP:        cfg_reg.min_release_gap <= pwdata[DLY_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (sel_idx)
            REG_SAMPLE_PERIOD:  prdata = DATA_W'(cfg_reg.sample_period);
            REG_RESTART_PERIOD: prdata = DATA_W'(cfg_reg.restart_period);
            REG_NORMAL_DELAY:   prdata = DATA_W'(cfg_reg.normal_delay);
            REG_ABNORMAL_DELAY: prdata = DATA_W'(cfg_reg.abnormal_delay);
            REG_SENSOR_DELAY:   prdata = DATA_W'(cfg_reg.sensor_delay);
            REG_MIN_GAP:        prdata = DATA_W'(cfg_reg.min_release_gap);
            default:            prdata = '0;
        endcase
    end

endmodule

// ===== rtl/timestamped_link_delay_emulator_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timestamped_link_delay_emulator_unit
// Ring buffer that delays timestamped samples to emulate a lossy link.
// ----------------------------------------------------------------------------
// Each input transaction is one millisecond tick and produces exactly one
// output transaction, at one tick per cycle unless the output stalls: the
// tick is registered, then the sampling, restart and release decisions and the
// ring buffer write and read are made in one pass into the output register.
// Back-to-back ticks work because the buffer pointers and timers update at the
// end of that single pass. s_axis_tready drops only while the output register
// holds an untaken result and the input register is full. The 32-entry buffer
// is read at the read pointer in the same cycle as a sample is written, and a
// write to the slot being read is forwarded. Entries never written since reset
// read as zero. m_axis_tuser is high when a sample was released on that tick;
// m_axis_tdata always shows the last released sample.
module timestamped_link_delay_emulator_unit (
    input  logic                         clk,
    input  logic                         rst_n,
    // APB configuration
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [tlde_pkg::ADDR_W-1:0]  paddr,
    input  logic [tlde_pkg::DATA_W-1:0]  pwdata,
    output logic [tlde_pkg::DATA_W-1:0]  prdata,
    output logic                         pready,
    // tick stream in
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    // now_time[31:0], in_x[63:32], in_y[95:64], in_heading[127:96],
    // jitter[137:128], zero [143:138]
    input  logic [tlde_pkg::S_DATA_W-1:0] s_axis_tdata,
    // result stream out
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    // out_x[31:0], out_y[63:32], out_heading[95:64]
    output logic [tlde_pkg::M_DATA_W-1:0] m_axis_tdata,
    // released[0]
    output logic                         m_axis_tuser
);
    import tlde_pkg::*;

    tlde_cfg_t cfg;

    // input stage
    logic                in_valid_reg;
    logic [TIME_W-1:0]   in_now_reg;
    logic [SLOT_W-1:0]   in_vals_reg;
    logic [JIT_W-1:0]    in_jit_reg;

    // output stage, doubles as the held sample
    logic                out_valid_reg;
    logic                out_rel_reg;
    logic [SLOT_W-1:0]   held_reg;

    // ring buffer
    logic [TIME_W-1:0]   slot_time_reg [BUF_DEPTH];
    logic [SLOT_W-1:0]   slot_vals_reg [BUF_DEPTH];
    logic [BUF_DEPTH-1:0] slot_ok_reg;

    // timers and pointers
    idx_t                wr_idx_reg, wr_idx_next;
    idx_t                rd_idx_reg, rd_idx_next;
    logic signed [CMP_W-1:0] deadline_reg, deadline_next;
    logic [TIME_W-1:0]   restart_time_reg, restart_time_next;
    logic                pending_reg, pending_next;
    logic [TIME_W-1:0]   last_rel_reg, last_rel_next;

    logic                advance;
    logic                fire;
    logic                s_accept;

    logic                time_zero;
    logic signed [CMP_W-1:0] t_s, sp_s, rp_s, dly_s, sens_s, jit_s, gap_s;
    logic signed [CMP_W-1:0] dl_eff, age_s, slot_t_s, since_s, rt_s;
    idx_t                wr_eff, rd_eff;
    logic [TIME_W-1:0]   rt_eff, last_eff;
    logic                pend_eff, pend_now;
    logic                do_sample, do_restart, age_ok, gap_ok, rel;
    logic [TIME_W-1:0]   rd_time;
    logic [SLOT_W-1:0]   rd_vals;

    tlde_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign advance       = !out_valid_reg || m_axis_tready;
    assign fire          = in_valid_reg && advance;
    assign s_axis_tready = !in_valid_reg || advance;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_rel_reg;
    assign m_axis_tdata  = held_reg;

    always_comb
    begin
        time_zero = (in_now_reg == '0);
        t_s    = $signed(CMP_W'(in_now_reg));
        sp_s   = $signed(CMP_W'(cfg.sample_period));
        rp_s   = $signed(CMP_W'(cfg.restart_period));
        sens_s = $signed(CMP_W'(cfg.sensor_delay));
        jit_s  = $signed(CMP_W'(in_jit_reg));
        gap_s  = $signed(CMP_W'(cfg.min_release_gap));

        // a zero timestamp restarts timers and pointers before this tick runs
        dl_eff   = time_zero ? -sp_s : deadline_reg;
        rt_eff   = time_zero ? '0 : restart_time_reg;
        pend_eff = time_zero ? 1'b0 : pending_reg;
        wr_eff   = time_zero ? '0 : wr_idx_reg;
        rd_eff   = time_zero ? '0 : rd_idx_reg;
        last_eff = time_zero ? '0 : last_rel_reg;

        do_sample  = (t_s - sp_s) > dl_eff;
        rt_s       = $signed(CMP_W'(rt_eff));
        do_restart = (t_s - rp_s) > rt_s;
        pend_now   = pend_eff || do_restart;

        // read after this tick's write
        if (do_sample && (wr_eff == rd_eff))
        begin
            rd_time = in_now_reg;
            rd_vals = in_vals_reg;
        end
        else if (slot_ok_reg[rd_eff])
        begin
            rd_time = slot_time_reg[rd_eff];
            rd_vals = slot_vals_reg[rd_eff];
        end
        else
        begin
            rd_time = '0;
            rd_vals = '0;
        end

        dly_s    = pend_now ? $signed(CMP_W'(cfg.abnormal_delay))
                            : $signed(CMP_W'(cfg.normal_delay));
        age_s    = t_s - dly_s - sens_s - jit_s;
        slot_t_s = $signed(CMP_W'(rd_time));
        age_ok   = age_s > slot_t_s;
        since_s  = t_s - $signed(CMP_W'(last_eff));
        gap_ok   = since_s > gap_s;
        rel      = age_ok && (pend_now || gap_ok);

        deadline_next     = do_sample ? dl_eff + sp_s : dl_eff;
        wr_idx_next       = do_sample ? next_slot(wr_eff) : wr_eff;
        restart_time_next = do_restart ? in_now_reg : rt_eff;
        pending_next      = pend_now && !rel;
        // restart releases leave the gap timer alone
        last_rel_next     = (rel && !pend_now) ? in_now_reg : last_eff;
        rd_idx_next       = rel ? next_slot(rd_eff) : rd_eff;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            out_rel_reg      <= 1'b0;
            held_reg         <= '0;
            slot_ok_reg      <= '0;
            wr_idx_reg       <= '0;
            rd_idx_reg       <= '0;
            deadline_reg     <= -$signed(CMP_W'(SAMPLE_PERIOD_RST));
            restart_time_reg <= '0;
            pending_reg      <= 1'b0;
            last_rel_reg     <= '0;
        end
        else
        begin
            if (s_accept)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (fire)
            begin
                in_valid_reg <= 1'b0;
            end

            if (fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (fire)
            begin
                out_rel_reg      <= rel;
                if (rel)
                begin
                    held_reg <= rd_vals;
                end
                if (do_sample)
                begin
                    slot_ok_reg[wr_eff] <= 1'b1;
                end
                wr_idx_reg       <= wr_idx_next;
                rd_idx_reg       <= rd_idx_next;
                deadline_reg     <= deadline_next;
                restart_time_reg <= restart_time_next;
                pending_reg      <= pending_next;
                last_rel_reg     <= last_rel_next;
            end
        end
    end

    // payload storage, no reset
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            in_now_reg  <= s_axis_tdata[TIME_W-1:0];
            in_vals_reg <= s_axis_tdata[TIME_W +: SLOT_W];
            in_jit_reg  <= s_axis_tdata[TIME_W + SLOT_W +: JIT_W];
        end
        if (fire && do_sample)
        begin
            slot_time_reg[wr_eff] <= in_now_reg;
            slot_vals_reg[wr_eff] <= in_vals_reg;
        end
    end

endmodule

// ===== rtl/tlde_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlde_checker
// Port-level checks for the link delay emulator, bound to the top level.
// ----------------------------------------------------------------------------
module tlde_checker (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         pready,
    input  logic                         s_axis_tvalid,
    input  logic                         s_axis_tready,
    input  logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    input  logic [tlde_pkg::M_DATA_W-1:0] m_axis_tdata,
    input  logic                         m_axis_tuser
);
    import tlde_pkg::*;

    logic [M_DATA_W-1:0] last_data_reg;
    logic                m_xfer;

    assign m_xfer = m_axis_tvalid && m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_data_reg <= '0;
        end
        else if (m_xfer)
        begin
            last_data_reg <= m_axis_tdata;
        end
    end

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result changed");

    // input stalls only behind a blocked result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input stalled without output backpressure");

    // no release: the held sample is unchanged
    a_hold_value: assert property (@(posedge clk) disable iff (!rst_n)
        m_xfer && !m_axis_tuser |-> m_axis_tdata == last_data_reg)
        else $error("held sample changed without a release");

    a_pready: assert property (@(posedge clk) disable iff (!rst_n)
        pready)
        else $error("pready low");

endmodule

bind timestamped_link_delay_emulator_unit tlde_checker u_tlde_checker (.*);

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the timestamped link delay emulator. Ticks go in on
// the input stream, configuration goes over APB with read-back, and every
// output transaction is checked against an in-bench emulation of the ring
// buffer, the sampling and restart timers and the release rules.
// ----------------------------------------------------------------------------
module testbench;

    import tlde_pkg::*;

    localparam int QUIET_LIMIT = 5000;   // cycles with no transaction at all
    localparam int STALL_LEN   = 300;    // long output hold-off

    typedef struct {
        logic [TIME_W-1:0] now;
        logic [VAL_W-1:0]  x;
        logic [VAL_W-1:0]  y;
        logic [VAL_W-1:0]  hd;
        logic [JIT_W-1:0]  jit;
    } tick_t;

    typedef struct {
        logic              released;
        logic [VAL_W-1:0]  x;
        logic [VAL_W-1:0]  y;
        logic [VAL_W-1:0]  hd;
    } emu_out_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [ADDR_W-1:0]     paddr = '0;
    logic [DATA_W-1:0]     pwdata = '0;
    logic [DATA_W-1:0]     prdata;
    logic                  pready;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [S_DATA_W-1:0]   s_axis_tdata = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [M_DATA_W-1:0]   m_axis_tdata;
    logic                  m_axis_tuser;

    // emulated block state
    tlde_cfg_t             cfg;
    logic [TIME_W-1:0]     slot_ms [BUF_DEPTH];
    logic [VAL_W-1:0]      slot_val [BUF_DEPTH][3];
    int                    wr_idx;
    int                    rd_idx;
    longint                deadline;
    logic [TIME_W-1:0]     restart_ms;
    bit                    restart_pending;
    logic [TIME_W-1:0]     last_release_ms;
    logic [VAL_W-1:0]      held [3];

    emu_out_t              awaited_outputs [$];
    int                    failures = 0;
    int                    quiet_cycles = 0;
    int                    tx_idle_pct = 0;
    int                    rx_idle_pct = 0;
    int                    stall_requests = 0;
    int                    stall_served = 0;
    int                    stall_left = 0;

    timestamped_link_delay_emulator_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------------
    // emulation of the block
    // ------------------------------------------------------------------------
    function automatic void reinit_timers();
        deadline        = -longint'(cfg.sample_period);
        restart_ms      = '0;
        restart_pending = 1'b0;
        wr_idx          = 0;
        rd_idx          = 0;
        last_release_ms = '0;
    endfunction

    function automatic void reset_emulator();
        cfg.sample_period   = SAMPLE_PERIOD_RST;
        cfg.restart_period  = RESTART_PERIOD_RST;
        cfg.normal_delay    = NORMAL_DELAY_RST;
        cfg.abnormal_delay  = ABNORMAL_DELAY_RST;
        cfg.sensor_delay    = SENSOR_DELAY_RST;
        cfg.min_release_gap = MIN_GAP_RST;
        for (int i = 0; i < BUF_DEPTH; i++)
        begin
            slot_ms[i] = '0;
            for (int k = 0; k < 3; k++)
            begin
                slot_val[i][k] = '0;
            end
        end
        for (int k = 0; k < 3; k++)
        begin
            held[k] = '0;
        end
        reinit_timers();
    endfunction

    function automatic emu_out_t emulate_tick(input tick_t tk);
        emu_out_t res;
        longint   t;
        longint   jit;
        longint   age_limit;
        bit       rel;
        int       r;
        t   = longint'(tk.now);
        jit = longint'(tk.jit);
        rel = 1'b0;
        if (tk.now == '0)
        begin
            reinit_timers();
        end
        // capture
        if (t - longint'(cfg.sample_period) > deadline)
        begin
            slot_ms[wr_idx]     = tk.now;
            slot_val[wr_idx][0] = tk.x;
            slot_val[wr_idx][1] = tk.y;
            slot_val[wr_idx][2] = tk.hd;
            wr_idx   = (wr_idx == BUF_DEPTH - 1) ? 0 : wr_idx + 1;
            deadline = deadline + longint'(cfg.sample_period);
        end
        // periodic restart
        if (t - longint'(cfg.restart_period) > longint'(restart_ms))
        begin
            restart_ms      = tk.now;
            restart_pending = 1'b1;
        end
        r = rd_idx;
        if (restart_pending)
        begin
            age_limit = t - longint'(cfg.abnormal_delay) - longint'(cfg.sensor_delay) - jit;
            if (age_limit > longint'(slot_ms[r]))
            begin
                rel             = 1'b1;
                restart_pending = 1'b0;
            end
        end
        else
        begin
            age_limit = t - longint'(cfg.normal_delay) - longint'(cfg.sensor_delay) - jit;
            if (age_limit > longint'(slot_ms[r]) &&
                t - longint'(last_release_ms) > longint'(cfg.min_release_gap))
            begin
                rel             = 1'b1;
                last_release_ms = tk.now;
            end
        end
        if (rel)
        begin
            for (int k = 0; k < 3; k++)
            begin
                held[k] = slot_val[r][k];
            end
            rd_idx = (r == BUF_DEPTH - 1) ? 0 : r + 1;
        end
        res.released = rel;
        res.x        = held[0];
        res.y        = held[1];
        res.hd       = held[2];
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // monitor: predict on input transactions, check output transactions
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        emu_out_t want;
        tick_t    tk;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (awaited_outputs.size() == 0)
                begin
                    $error("output transaction with no tick outstanding");
                    failures++;
                end
                else
                begin
                    want = awaited_outputs.pop_front();
                    if (m_axis_tuser !== want.released)
                    begin
                        $error("released: expected %0d, got %0d", want.released, m_axis_tuser);
                        failures++;
                    end
                    if (m_axis_tdata[31:0] !== want.x)
                    begin
                        $error("out_x: expected %h, got %h", want.x, m_axis_tdata[31:0]);
                        failures++;
                    end
                    if (m_axis_tdata[63:32] !== want.y)
                    begin
                        $error("out_y: expected %h, got %h", want.y, m_axis_tdata[63:32]);
                        failures++;
                    end
                    if (m_axis_tdata[95:64] !== want.hd)
                    begin
                        $error("out_heading: expected %h, got %h", want.hd,
                               m_axis_tdata[95:64]);
                        failures++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                tk.now = s_axis_tdata[31:0];
                tk.x   = s_axis_tdata[63:32];
                tk.y   = s_axis_tdata[95:64];
                tk.hd  = s_axis_tdata[127:96];
                tk.jit = s_axis_tdata[137:128];
                awaited_outputs.push_back(emulate_tick(tk));
            end
            if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready) ||
                (psel && penable && pready))
            begin
                quiet_cycles = 0;
            end
            else
            begin
                quiet_cycles++;
                if (quiet_cycles >= QUIET_LIMIT)
                begin
                    $display("Verification failed");
                    $finish;
                end
            end
        end
    end

    // output side ready: random idling plus requested long hold-offs
    always @(posedge clk)
    begin
        if (stall_requests != stall_served)
        begin
            stall_served = stall_requests;
            stall_left   = STALL_LEN;
        end
        if (stall_left > 0)
        begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // ------------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------------
    task automatic send_tick(input tick_t tk);
        if ($urandom_range(99) < tx_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'b0, tk.jit, tk.hd, tk.y, tk.x, tk.now};
        do @(posedge clk); while (!s_axis_tready);
    endtask

    task automatic wait_until_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (awaited_outputs.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    // write, then read back; the mirror keeps only the register's width
    task automatic write_register(input reg_idx_t idx, input logic [DATA_W-1:0] value);
        logic [DATA_W-1:0] stored;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        stored = '0;
        case (idx)
            REG_SAMPLE_PERIOD:
            begin
                cfg.sample_period = value[SPER_W-1:0];
                stored[SPER_W-1:0] = value[SPER_W-1:0];
            end
            REG_RESTART_PERIOD:
            begin
                cfg.restart_period = value[RPER_W-1:0];
                stored[RPER_W-1:0] = value[RPER_W-1:0];
            end
            REG_NORMAL_DELAY:
            begin
                cfg.normal_delay = value[DLY_W-1:0];
                stored[DLY_W-1:0] = value[DLY_W-1:0];
            end
            REG_ABNORMAL_DELAY:
            begin
                cfg.abnormal_delay = value[DLY_W-1:0];
                stored[DLY_W-1:0] = value[DLY_W-1:0];
            end
            REG_SENSOR_DELAY:
            begin
                cfg.sensor_delay = value[DLY_W-1:0];
                stored[DLY_W-1:0] = value[DLY_W-1:0];
            end
            REG_MIN_GAP:
            begin
                cfg.min_release_gap = value[DLY_W-1:0];
                stored[DLY_W-1:0] = value[DLY_W-1:0];
            end
            default:
            begin
            end
        endcase
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata !== stored)
        begin
            $error("register %s: expected %h, got %h", idx.name(), stored, prdata);
            failures++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic program_registers(input logic [DATA_W-1:0] sp, input logic [DATA_W-1:0] rp,
                                     input logic [DATA_W-1:0] nd, input logic [DATA_W-1:0] ad,
                                     input logic [DATA_W-1:0] sd, input logic [DATA_W-1:0] gap);
        wait_until_drained();
        write_register(REG_SAMPLE_PERIOD, sp);
        write_register(REG_RESTART_PERIOD, rp);
        write_register(REG_NORMAL_DELAY, nd);
        write_register(REG_ABNORMAL_DELAY, ad);
        write_register(REG_SENSOR_DELAY, sd);
        write_register(REG_MIN_GAP, gap);
    endtask

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------
    function automatic tick_t tick_of(input logic [31:0] now, input logic [31:0] x,
                                      input logic [31:0] y, input logic [31:0] hd,
                                      input logic [9:0] jit);
        tick_t tk;
        tk.now = now;
        tk.x   = x;
        tk.y   = y;
        tk.hd  = hd;
        tk.jit = jit;
        return tk;
    endfunction

    function automatic tick_t random_tick(input logic [31:0] now);
        logic [9:0] jit;
        // mostly small jitter so releases keep happening
        jit = ($urandom_range(9) < 7) ? 10'($urandom_range(15)) : 10'($urandom);
        return tick_of(now, $urandom, $urandom, $urandom, jit);
    endfunction

    // rising time from zero, with some restarts, backward steps and wild times
    task automatic run_timeline(input int count, input int max_step);
        logic [31:0] now;
        int          pick;
        now = '0;
        send_tick(random_tick(now));
        for (int i = 1; i < count; i++)
        begin
            pick = $urandom_range(99);
            if (pick < 3)
                now = '0;
            else if (pick < 6)
                now = now - 32'($urandom_range(200, 1));
            else if (pick < 8)
                now = $urandom;
            else
                now = now + 32'($urandom_range(max_step, 1));
            send_tick(random_tick(now));
        end
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------
    task automatic test_directed_ticks();
        tx_idle_pct = 22;
        rx_idle_pct = 72;
        // reset register values
        send_tick(tick_of(32'd0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 10'd0));
        send_tick(tick_of(32'd1, 32'hFFFF_FFFF, 32'h0000_0001, 32'h7FFF_FFFF, 10'd0));
        send_tick(tick_of(32'd40, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 10'h3FF));
        send_tick(tick_of(32'd40, 32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 10'd0));
        send_tick(tick_of(32'd41, 32'h1234_5678, 32'h0, 32'h0, 10'd0));
        send_tick(tick_of(32'd45, 32'h0, 32'h0, 32'h0, 10'd0));
        // read pointer runs past the write pointer into unwritten slots
        send_tick(tick_of(32'd47, 32'hAAAA_AAAA, 32'h5555_5555, 32'h0, 10'd0));
        send_tick(tick_of(32'd60, 32'h5555_5555, 32'hAAAA_AAAA, 32'h0, 10'd0));
        // time going backwards
        send_tick(tick_of(32'd20, 32'h0, 32'h0, 32'h0, 10'd0));
        // restart release with the abnormal delay
        send_tick(tick_of(32'd10020, 32'h0001_0000, 32'hFFFF_0000, 32'h0, 10'd0));
        send_tick(tick_of(32'd10021, 32'h0, 32'h0, 32'h0, 10'd0));
        send_tick(tick_of(32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 10'h3FF));
        send_tick(tick_of(32'hFFFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 10'd0));
        // time zero keeps the buffer but resets the timers
        send_tick(tick_of(32'd0, 32'h0, 32'h0, 32'h0, 10'h3FF));
        send_tick(tick_of(32'd5, 32'h0, 32'h0, 32'h0, 10'd0));
        program_registers(32'd10, 32'd100, 32'd2, 32'd500, 32'd3, 32'd0);
        for (int i = 0; i < 10; i++)
        begin
            send_tick(tick_of(32'(i * 60), $urandom, $urandom, $urandom, 10'(i)));
        end
    endtask

    task automatic test_register_extremes();
        program_registers(32'd1, 32'd1, 32'd0, 32'd0, 32'd0, 32'd0);
        run_timeline(40, 3);
        program_registers(32'd65535, 32'd1000000, 32'd65535, 32'd65535, 32'd65535,
                          32'd65535);
        run_timeline(40, 100000);
        // zero periods
        program_registers(32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
        run_timeline(40, 5);
        // bits above each register's width are dropped
        program_registers(32'hABCD_0021, 32'hFFF0_03E8, 32'hFFFF_0004, 32'h8000_0032,
                          32'h0F0F_0002, 32'hFFFF_0003);
        run_timeline(40, 10);
        program_registers(32'd33, 32'd10000, 32'd0, 32'd0, 32'd0, 32'd1);
        run_timeline(40, 50);
    endtask

    task automatic test_random_timelines();
        for (int ph = 0; ph < 9; ph++)
        begin
            if (ph < 3)
            begin
                tx_idle_pct = 22;
                rx_idle_pct = 72;
            end
            else if (ph < 6)
            begin
                tx_idle_pct = 72;
                rx_idle_pct = 22;
            end
            else
            begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            program_registers($urandom_range(50, 1), $urandom_range(2000, 1),
                              $urandom_range(60, 0), $urandom_range(300, 0),
                              $urandom_range(20, 0), $urandom_range(10, 0));
            run_timeline(145, $urandom_range(20, 1));
        end
    endtask

    // output held off while ticks keep coming, so the input side must stall
    task automatic test_output_stall();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        stall_requests++;
        run_timeline(40, 10);
    endtask

    initial
    begin
        reset_emulator();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_ticks();
        test_register_extremes();
        test_random_timelines();
        test_output_stall();
        wait_until_drained();
        repeat (10) @(posedge clk);
        if (failures == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
